// ----- hw/rtl/esae_pkg.sv -----
// ============================================================================
// esae_pkg: shared constants for the encoder speed and angle estimator
// Widths, line count, fixed-point constants and the derived step counts of
// the bit-serial multipliers, the modulo reduction and the angle divider.
// ============================================================================
package esae_pkg;

    localparam int CHANNELS   = 2;
    localparam int LINES      = 4000;
    localparam int CNT_W      = 16;
    localparam int CH_W       = 1;
    localparam int SPEED_W    = 32;
    localparam int SCALE_W    = 32;
    localparam int ALPHA_W    = 17;
    localparam int ANGLE_W    = 16;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 16;

    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);

    // 2*pi with 29 fraction bits
    localparam logic [SCALE_W-1:0] TWO_PI_Q29 = 32'hC90F_DAA2;

    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd2058874;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd1;

    // Position modulo LINES: pos + diff is offset to nonnegative, then
    // reduced by compare-subtract of LINES << k, k = MOD_STEPS-1 .. 0.
    localparam int HALF_RANGE = 2 ** (CNT_W - 1);
    localparam int MOD_STEPS  = $clog2(HALF_RANGE / LINES + 2);
    localparam int MOD_W      = $clog2(LINES * (2 ** MOD_STEPS));
    localparam int SUM_W      = MOD_W + 2;
    localparam int MOD_OFFS   = LINES * (HALF_RANGE / LINES + 1);

    // Angle: round(pos * TWO_PI_Q29 / (LINES * 2^16))
    localparam int ANG_NUM_W = POS_W + SCALE_W;
    localparam logic [ANG_NUM_W-1:0] ANG_RND =
        ANG_NUM_W'(longint'(LINES) << (FRAC_W - 1));
    localparam logic [ANG_NUM_W-1:0] ANG_DIV_TOP =
        ANG_NUM_W'(longint'(LINES) << (FRAC_W + ANGLE_W - 1));

    // Step counter covers the longest serial pass (the alpha multiply)
    localparam int STEP_W = $clog2(ALPHA_W);

endpackage

// ----- hw/rtl/encoder_speed_angle_estimator.sv -----
// ============================================================================
// encoder_speed_angle_estimator: two-channel quadrature speed/angle estimator
// Wrapped count difference, scaling to rad/s, first-order IIR smoothing,
// position modulo the line count and mechanical angle, all bit-serial.
// ============================================================================
// One sample is processed at a time; o_in_ready is high again only after
// the following steps: the shift-add multiply of the count difference by
// speed_scale (one difference bit per cycle, the position modulo reduction
// runs alongside), saturation, the shift-add multiply of the IIR update by
// alpha (one alpha bit per cycle, the angle multiply runs alongside), the
// filter sum, restoring division for the angle (one quotient bit per cycle)
// and a handoff to the output register, which waits while the previous
// result is not taken. The result sits in an output register, so a new
// sample is taken while the previous result still waits for i_out_ready.
// Speed is Q16.16 rad/s, angle is Q3.13 radians, position counts modulo
// the line count. Configuration is to be written through a plain write port
// while idle; the user is bound to this, the block itself does not enforce it.
module encoder_speed_angle_estimator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [esae_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [esae_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [esae_pkg::CH_W-1:0]        i_channel,
    input  logic [esae_pkg::CNT_W-1:0]       i_count,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [esae_pkg::SPEED_W-1:0] o_speed,
    output logic [esae_pkg::ANGLE_W-1:0]     o_angle,
    output logic [esae_pkg::POS_W-1:0]       o_position,
    output logic                             o_saturated
);
    import esae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_MIX,
        S_FILT,
        S_FIN,
        S_DIV,
        S_HOLD
    } t_state;

    localparam int M1_W = SCALE_W + CNT_W;   // scale product width
    localparam int F_HI_W = SPEED_W + 2;     // filter accumulator, high part

    t_state                 r_state;
    logic [STEP_W-1:0]      r_cnt;

    // configuration
    logic [SCALE_W-1:0]     r_speed_scale;
    logic [ALPHA_W-1:0]     r_alpha;

    // per-channel state
    logic [CNT_W-1:0]       r_prev_count [CHANNELS];
    logic [SPEED_W-1:0]     r_prev_spd   [CHANNELS];
    logic [POS_W-1:0]       r_pos        [CHANNELS];

    // current transaction
    logic [CH_W-1:0]        r_ch;
    logic                   r_neg;
    logic [SPEED_W-1:0]     r_prev_speed;
    logic                   r_sat;
    logic [SPEED_W-1:0]     r_spd_new;
    logic [POS_W-1:0]       r_pos_new;

    // scale multiplier: {hi, lo}, lo starts as |diff|
    logic [SCALE_W:0]       r_m1_hi;
    logic [CNT_W-1:0]       r_m1_lo;
    // modulo reduction
    logic [MOD_W-1:0]       r_mod_val;
    logic [MOD_W-1:0]       r_mod_sub;
    // filter multiplier: signed difference times unsigned alpha
    logic [SPEED_W:0]       r_dif;
    logic [F_HI_W-1:0]      r_f_hi;
    logic [ALPHA_W-1:0]     r_f_lo;
    // angle multiplier and divider
    logic [SCALE_W:0]       r_a_hi;
    logic [POS_W-1:0]       r_a_lo;
    logic [ANG_NUM_W-1:0]   r_rem;
    logic [ANG_NUM_W-1:0]   r_dsub;
    logic [ANGLE_W-1:0]     r_quo;

    // outputs
    logic                   r_out_valid;
    logic [SPEED_W-1:0]     r_speed;
    logic [ANGLE_W-1:0]     r_angle;
    logic [POS_W-1:0]       r_position;
    logic                   r_saturated;

    // --- accept-time logic ---
    logic                   in_fire;
    logic [CNT_W-1:0]       diff;
    logic [CNT_W-1:0]       diff_mag;
    logic signed [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0]       pos_adj;

    assign in_fire  = i_in_valid && o_in_ready;
    assign diff     = i_count - r_prev_count[i_channel];
    assign diff_mag = diff[CNT_W-1] ? (~diff + CNT_W'(1)) : diff;
    assign pos_sum  = $signed({{(SUM_W-CNT_W){diff[CNT_W-1]}}, diff})
                    + $signed({{(SUM_W-POS_W){1'b0}}, r_pos[i_channel]});
    assign pos_adj  = pos_sum[SUM_W-1] ? (SUM_W'(pos_sum) + SUM_W'(MOD_OFFS))
                                       : SUM_W'(pos_sum);

    // --- serial steps ---
    logic [SCALE_W:0]       m1_sum;
    logic [F_HI_W-1:0]      f_sum;
    logic [SCALE_W:0]       a_sum;
    logic                   mod_ge;
    logic                   div_ge;

    assign m1_sum = r_m1_hi + (r_m1_lo[0] ? {1'b0, r_speed_scale} : '0);
    assign f_sum  = r_f_hi + (r_f_lo[0] ? {r_dif[SPEED_W], r_dif} : '0);
    assign a_sum  = r_a_hi + (r_a_lo[0] ? {1'b0, TWO_PI_Q29} : '0);
    assign mod_ge = (r_mod_val >= r_mod_sub);
    assign div_ge = (r_rem >= r_dsub);

    // --- saturation of the scaled difference ---
    logic [M1_W-1:0]        prod;
    logic                   prod_ovf;
    logic                   prod_min;
    logic                   sat;
    logic [SPEED_W-1:0]     raw;
    logic [SPEED_W:0]       dif;
    logic [ALPHA_W-1:0]     alpha_eff;

    assign prod     = {r_m1_hi[M1_W-CNT_W-1:0], r_m1_lo};
    assign prod_ovf = |prod[M1_W-1:SPEED_W-1];
    // exactly 2^31 still fits when the difference is negative
    assign prod_min = (prod[M1_W-1:SPEED_W-1] == (M1_W-SPEED_W+1)'(1))
                   && (prod[SPEED_W-2:0] == '0);
    assign sat      = prod_ovf && !(r_neg && prod_min);
    always_comb begin
        if (sat) begin
            raw = r_neg ? {1'b1, {(SPEED_W-1){1'b0}}} : {1'b0, {(SPEED_W-1){1'b1}}};
        end else if (r_neg) begin
            raw = ~prod[SPEED_W-1:0] + SPEED_W'(1);
        end else begin
            raw = prod[SPEED_W-1:0];
        end
    end
    assign dif       = {raw[SPEED_W-1], raw} - {r_prev_speed[SPEED_W-1], r_prev_speed};
    assign alpha_eff = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;

    // --- filter output: prev + round(alpha*dif / 2^16) ---
    logic [F_HI_W:0]        spd_sum;
    assign spd_sum = {{(F_HI_W+1-SPEED_W){r_prev_speed[SPEED_W-1]}}, r_prev_speed}
                   + {r_f_hi, r_f_lo[FRAC_W]}
                   + (F_HI_W+1)'(r_f_lo[FRAC_W-1]);

    logic                   out_free;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_speed_scale <= SCALE_RST;
            r_alpha       <= ALPHA_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                r_prev_count[i] <= '0;
                r_prev_spd[i]   <= '0;
                r_pos[i]        <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_SPEED_SCALE: r_speed_scale <= i_cfg_data[SCALE_W-1:0];
                    REG_ALPHA:       r_alpha       <= i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_prev_count[i_channel] <= i_count;
                        r_ch         <= i_channel;
                        r_neg        <= diff[CNT_W-1];
                        r_prev_speed <= r_prev_spd[i_channel];
                        r_m1_hi      <= '0;
                        r_m1_lo      <= diff_mag;
                        r_mod_val    <= pos_adj[MOD_W-1:0];
                        r_mod_sub    <= MOD_W'(LINES * (2 ** (MOD_STEPS - 1)));
                        r_cnt        <= '0;
                        r_state      <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_m1_hi <= {1'b0, m1_sum[SCALE_W:1]};
                    r_m1_lo <= {m1_sum[0], r_m1_lo[CNT_W-1:1]};
                    if (r_cnt < STEP_W'(MOD_STEPS)) begin
                        if (mod_ge) begin
                            r_mod_val <= r_mod_val - r_mod_sub;
                        end
                        r_mod_sub <= r_mod_sub >> 1;
                    end
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_W'(CNT_W - 1)) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_sat     <= sat;
                    r_dif     <= dif;
                    r_f_hi    <= '0;
                    r_f_lo    <= alpha_eff;
                    r_pos[r_ch] <= r_mod_val[POS_W-1:0];
                    r_pos_new <= r_mod_val[POS_W-1:0];
                    r_a_hi    <= '0;
                    r_a_lo    <= r_mod_val[POS_W-1:0];
                    r_cnt     <= '0;
                    r_state   <= S_FILT;
                end
                S_FILT: begin
                    // arithmetic right shift of the signed accumulator
                    r_f_hi <= {f_sum[F_HI_W-1], f_sum[F_HI_W-1:1]};
                    r_f_lo <= {f_sum[0], r_f_lo[ALPHA_W-1:1]};
                    if (r_cnt < STEP_W'(POS_W)) begin
                        r_a_hi <= {1'b0, a_sum[SCALE_W:1]};
                        r_a_lo <= {a_sum[0], r_a_lo[POS_W-1:1]};
                    end
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_W'(ALPHA_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_spd_new        <= spd_sum[SPEED_W-1:0];
                    r_prev_spd[r_ch] <= spd_sum[SPEED_W-1:0];
                    r_rem   <= ANG_NUM_W'({r_a_hi, r_a_lo}) + ANG_RND;
                    r_dsub  <= ANG_DIV_TOP;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= r_rem - r_dsub;
                    end
                    r_quo  <= {r_quo[ANGLE_W-2:0], div_ge};
                    r_dsub <= r_dsub >> 1;
                    r_cnt  <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_W'(ANGLE_W - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_speed     <= r_spd_new;
                        r_angle     <= r_quo;
                        r_position  <= r_pos_new;
                        r_saturated <= r_sat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_speed     = $signed(r_speed);
    assign o_angle     = r_angle;
    assign o_position  = r_position;
    assign o_saturated = r_saturated;

endmodule
